// ===== rtl/core/fpd_pkg.sv =====
// Package: shared types, constants and the fault pattern table of the fault pattern detector.
`default_nettype none

package fpd_pkg;

    localparam int NUM_ERRORS = 17;
    localparam int NUM_BYTES  = 7;
    localparam int CODE_W     = 5;
    localparam int MOD_W      = 3;

    typedef logic [NUM_ERRORS-1:0] t_err_vec;

    typedef struct packed {
        logic [2:0] module_req;
        logic [7:0] byte_count;
        logic [7:0] stat_r05;
        logic [7:0] stat_r06;
        logic [7:0] stat_r08;
        logic [7:0] stat_r09;
        logic [7:0] stat_r0a;
        logic [7:0] stat_r0b;
        logic [7:0] stat_r33;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_module;
        logic [4:0] error_code;
        logic       last_event;
    } t_out_item;

    // One unit of work for the back end: a module and its newly raised errors.
    typedef struct packed {
        logic [MOD_W-1:0] module_idx;
        t_err_vec         new_mask;
    } t_task;

    // Queue handshake between the front and back ends.
    typedef struct packed {
        logic  push;
        t_task data;
    } t_push;

    typedef struct packed {
        logic  full;
        logic  empty;
        t_task head;
    } t_q_status;

    // Buffer position of each status byte.
    localparam logic [7:0] BYTE_POS [NUM_BYTES] = '{
        8'd0, 8'd1, 8'd3, 8'd4, 8'd5, 8'd6, 8'd46
    };

    localparam logic [7:0] ERR_TABLE [NUM_ERRORS][NUM_BYTES] = '{
        '{8'h02, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h02, 8'h00, 8'h02, 8'h00, 8'h00},
        '{8'h02, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h02, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08},
        '{8'h00, 8'h00, 8'h00, 8'h10, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h80, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h20, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h0F, 8'h02, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hF0, 8'h00},
        '{8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00}
    };

endpackage

`default_nettype wire

// ===== rtl/core/fpd_front.sv =====
// Front end: pattern matching, per-module flag store and hand-off of newly raised errors.
`default_nettype none

module fpd_front
    import fpd_pkg::*;
#(
    parameter int MODULES = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    input  wire t_q_status i_q_status,
    output logic           o_in_stall,
    output t_push          o_push
);

    localparam int IDX_W = (MODULES > 1) ? $clog2(MODULES) : 1;

    t_err_vec         r_flags [MODULES];
    logic [7:0]       bytes [NUM_BYTES];
    logic             count_ok;
    logic             in_range;
    logic             accept;
    logic [31:0]      mod_ext;
    logic [IDX_W-1:0] idx;
    t_err_vec         match;
    t_err_vec         old_flags;
    t_err_vec         new_mask;

    assign bytes[0] = i_in_data.stat_r05;
    assign bytes[1] = i_in_data.stat_r06;
    assign bytes[2] = i_in_data.stat_r08;
    assign bytes[3] = i_in_data.stat_r09;
    assign bytes[4] = i_in_data.stat_r0a;
    assign bytes[5] = i_in_data.stat_r0b;
    assign bytes[6] = i_in_data.stat_r33;

    assign mod_ext  = 32'(i_in_data.module_req);
    assign idx      = mod_ext[IDX_W-1:0];
    assign in_range = (mod_ext < 32'(MODULES));
    assign accept   = i_in_valid && !i_q_status.full;

    always_comb begin
        count_ok = 1'b1;
        for (int k = 0; k < NUM_BYTES; k++) begin
            if (BYTE_POS[k] >= i_in_data.byte_count) begin
                count_ok = 1'b0;
            end
        end
        for (int e = 0; e < NUM_ERRORS; e++) begin
            match[e] = count_ok;
            for (int k = 0; k < NUM_BYTES; k++) begin
                if ((bytes[k] & ERR_TABLE[e][k]) != ERR_TABLE[e][k]) begin
                    match[e] = 1'b0;
                end
            end
        end
    end

    assign old_flags = in_range ? r_flags[idx] : '0;
    assign new_mask  = match & ~old_flags;

    // A flag simply follows the latest match result of its error.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MODULES; m++) begin
                r_flags[m] <= '0;
            end
        end else if (accept && in_range) begin
            r_flags[idx] <= match;
        end
    end

    assign o_in_stall           = i_q_status.full;
    assign o_push.push          = accept && in_range && (new_mask != '0);
    assign o_push.data.module_idx = i_in_data.module_req;
    assign o_push.data.new_mask = new_mask;

endmodule

`default_nettype wire

// ===== rtl/core/fpd_queue.sv =====
// Two-entry queue of event work between the front and back ends.
`default_nettype none

module fpd_queue
    import fpd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop,
    output t_q_status  o_status
);

    t_task      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign do_push = i_push.push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_status.head  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/core/fpd_back.sv =====
// Back end: emits one event per cycle from each queued mask while the output is not stalled, lowest error first.
`default_nettype none

module fpd_back
    import fpd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_q_status,
    input  wire logic      i_out_stall,
    output logic           o_pop,
    output logic           o_out_valid,
    output t_out_item      o_out_data
);

    logic             r_busy;
    t_err_vec         r_mask;
    logic [MOD_W-1:0] r_module;
    t_err_vec         lowest;
    t_err_vec         rest;
    logic [CODE_W-1:0] code;
    logic             xfer;
    logic             last;

    assign lowest = r_mask & ((~r_mask) + {{(NUM_ERRORS-1){1'b0}}, 1'b1});
    assign rest   = r_mask & ~lowest;
    assign last   = (rest == '0);
    assign xfer   = r_busy && !i_out_stall;

    always_comb begin
        code = '0;
        for (int e = 0; e < NUM_ERRORS; e++) begin
            if (lowest[e]) begin
                code = code | CODE_W'(e);
            end
        end
    end

    // Take new work when idle or when the final event of the current mask leaves.
    assign o_pop = !i_q_status.empty && (!r_busy || (xfer && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (xfer && last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mask   <= i_q_status.head.new_mask;
            r_module <= i_q_status.head.module_idx;
        end else if (xfer) begin
            r_mask <= rest;
        end
    end

    assign o_out_valid             = r_busy;
    assign o_out_data.event_module = r_module;
    assign o_out_data.error_code   = code;
    assign o_out_data.last_event   = last;

endmodule

`default_nettype wire

// ===== rtl/core/pmic_fault_pattern_event_detector_unit.sv =====
// Top level of the power-controller fault pattern event detector.
//
// The input channel takes one status snapshot per transfer: a module index, the
// valid byte count of the status buffer and seven status bytes. Each snapshot is
// checked against the seventeen fault patterns combinationally, and the
// per-module flag store is updated in the cycle of the transfer, so the next snapshot may
// follow immediately. Snapshots that raise nothing, or that name a module at or
// beyond MODULES, leave no trace on the output.
// Each newly raised error becomes one output transfer carrying the module, the
// error code and a last-event marker; events of one snapshot leave in ascending
// error order. The events of a snapshot are first written to the queue and then loaded
// into the mask register of the back end before the first of them is offered.
// The back end then delivers one event per cycle while the output is not stalled,
// so a snapshot yields from zero to seventeen events, issued by the serialiser.
// A two-entry queue sits between the matcher and the serialiser. The input is
// stalled only while that queue is full; a stall on the output holds the current
// event stable and, once the queue fills, backs up into the input channel.
// Reset is synchronous and active low: it clears every raised flag, empties the
// queue and drops any event in flight. No clearing pass is needed afterwards.
`default_nettype none

module pmic_fault_pattern_event_detector_unit
    import fpd_pkg::*;
#(
    parameter int MODULES = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_item     o_out_data
);

    t_push     push;
    t_q_status q_status;
    logic      pop;

    // Matching and flag bookkeeping happen as the snapshot is transferred in.
    fpd_front #(
        .MODULES (MODULES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_in_stall (o_in_stall),
        .o_push     (push)
    );

    // Only snapshots with at least one new error are queued.
    fpd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_status (q_status)
    );

    // The serialiser picks the lowest pending error on every output transfer.
    fpd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
